>>> rtl/sfcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcp_pkg: shared types, constants and CRC helper
// Holds the item layout, queue status and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam int SAMPLE_FIELDS = 4;
    localparam int SAMPLE_W      = 16;
    localparam int BYTE_W        = 8;
    localparam int ITEM_W        = SAMPLE_FIELDS * SAMPLE_W;
    localparam int CRC_W         = 16;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef logic [ITEM_W-1:0] item_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CRC_W-1:0]  crc_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // Fold one byte into the reflected CRC, one bit per step.
    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sfcp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcp_front: command intake
// Captures one sample beat and hands it to the queue when there is room.
// ----------------------------------------------------------------------------
module sfcp_front
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire signed [15:0]       sample_0,
    input  wire signed [15:0]       sample_1,
    input  wire signed [15:0]       sample_2,
    input  wire signed [15:0]       sample_3,
    input  sfcp_pkg::q_stat_t       q_stat,
    output logic                    busy,
    output logic                    push,
    output sfcp_pkg::item_t         item
);

    logic            valid_reg;
    logic            valid_next;
    sfcp_pkg::item_t item_reg;
    logic            accept;

    assign busy   = valid_reg & q_stat.full;
    assign push   = valid_reg & ~q_stat.full;
    assign accept = start & ~busy;
    assign item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Pack channel 0 in the low bits so the back end can shift bytes out.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= {sample_3, sample_2, sample_1, sample_0};
        end
    end

endmodule
`default_nettype wire

>>> rtl/sfcp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcp_queue: two-entry item queue
// Decouples intake from frame serialization.
// ----------------------------------------------------------------------------
module sfcp_queue
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  sfcp_pkg::item_t         push_item,
    input  wire                     pop,
    output sfcp_pkg::item_t         pop_item,
    output sfcp_pkg::q_stat_t       q_stat
);

    sfcp_pkg::item_t                  mem [sfcp_pkg::QDEPTH];
    logic [sfcp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sfcp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sfcp_pkg::QCNT_W-1:0]      count_reg;
    logic [sfcp_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign q_stat.full      = (count_reg == sfcp_pkg::QCNT_W'(sfcp_pkg::QDEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign do_push  = push & ~q_stat.full;
    assign do_pop   = pop & q_stat.not_empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sfcp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcp_back: frame serializer
// Shifts sample bytes out one per cycle, folds them into the CRC, then
// appends the CRC low and high bytes.
// ----------------------------------------------------------------------------
module sfcp_back
#(
    parameter int CHANNELS = 4
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  sfcp_pkg::q_stat_t       q_stat,
    input  sfcp_pkg::item_t         q_item,
    output logic                    pop,
    output logic                    strobe,
    output logic [7:0]              tx_byte,
    output logic                    frame_end
);

    localparam int USED        = (CHANNELS < 1) ? 1 :
                                 (CHANNELS > sfcp_pkg::SAMPLE_FIELDS) ?
                                 sfcp_pkg::SAMPLE_FIELDS : CHANNELS;
    localparam int DATA_BYTES  = 2 * USED;
    localparam int FRAME_BYTES = DATA_BYTES + 2;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    logic                   active_reg;
    logic                   active_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    sfcp_pkg::item_t        word_reg;
    sfcp_pkg::item_t        word_next;
    sfcp_pkg::crc_t         crc_reg;
    sfcp_pkg::crc_t         crc_next;
    sfcp_pkg::byte_t        cur_byte;
    logic                   data_phase;
    logic                   last;
    logic                   strobe_reg;
    logic                   frame_end_reg;
    sfcp_pkg::byte_t        tx_byte_reg;

    assign data_phase = (idx_reg < IDX_W'(DATA_BYTES));
    assign last       = active_reg & (idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign pop        = q_stat.not_empty & (~active_reg | last);

    always_comb
    begin
        if (data_phase)
        begin
            cur_byte = word_reg[sfcp_pkg::BYTE_W-1:0];
        end
        else if (idx_reg == IDX_W'(DATA_BYTES))
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = crc_reg[15:8];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        word_next   = word_reg;
        crc_next    = crc_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            word_next   = q_item;
            crc_next    = sfcp_pkg::CRC_INIT;
        end
        else if (last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            idx_next  = idx_reg + 1'b1;
            word_next = word_reg >> sfcp_pkg::BYTE_W;
            if (data_phase)
            begin
                crc_next = sfcp_pkg::crc_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            strobe_reg    <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            strobe_reg    <= active_reg;
            frame_end_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        crc_reg     <= crc_next;
        tx_byte_reg <= cur_byte;
    end

    assign strobe    = strobe_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

endmodule
`default_nettype wire

>>> rtl/sample_frame_crc16_packer_top.sv
`default_nettype none
// Path: intake register, queue entry, serializer word register, tx_byte
//   register; the frame's bytes then follow on consecutive cycles.
// Throughput: one frame of 2*channels+2 bytes (10 at CHANNELS = 4) at
//   the serializer's one byte per cycle while frames are queued.
// Reset: rst_n clears the intake register, the queue and the serializer;
//   no byte is strobed until a new item is accepted. Results cannot stall.
// ----------------------------------------------------------------------------
// sample_frame_crc16_packer_top: sample frame packer with CRC-16/MODBUS
// Packs CHANNELS (clamped 1..4) 16-bit samples low byte first into a
// byte stream plus a CRC-16/MODBUS trailer; the last byte carries frame_end.
// ----------------------------------------------------------------------------
module sample_frame_crc16_packer_top
#(
    parameter int CHANNELS = 4
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire signed [15:0]       sample_0,
    input  wire signed [15:0]       sample_1,
    input  wire signed [15:0]       sample_2,
    input  wire signed [15:0]       sample_3,
    output logic                    strobe,
    output logic [7:0]              tx_byte,
    output logic                    frame_end
);

    // Queue status goes back to both sides: intake waits on full, the
    // serializer pulls a ready entry when idle or on its last byte.
    sfcp_pkg::q_stat_t  q_stat;
    sfcp_pkg::item_t    front_item;
    sfcp_pkg::item_t    q_item;
    logic               push;
    logic               pop;

    // Front: take a beat whenever the intake register is free or draining.
    sfcp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .sample_0 (sample_0),
        .sample_1 (sample_1),
        .sample_2 (sample_2),
        .sample_3 (sample_3),
        .q_stat   (q_stat),
        .busy     (busy),
        .push     (push),
        .item     (front_item)
    );

    // Queue: hold up to two pending frames.
    sfcp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (q_item),
        .q_stat    (q_stat)
    );

    // Back: serialize bytes and the CRC trailer; load the next frame on the
    // last byte so frames run back to back.
    sfcp_back
    #(
        .CHANNELS (CHANNELS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_item    (q_item),
        .pop       (pop),
        .strobe    (strobe),
        .tx_byte   (tx_byte),
        .frame_end (frame_end)
    );

    // The end mark only rides on a strobed byte.
    assert property (@(posedge clk) disable iff (!rst_n) frame_end |-> strobe)
        else $error("frame_end without strobe");

    // Bytes of one frame are contiguous.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !frame_end) |=> strobe)
        else $error("gap inside a frame");

    // Intake only stalls when the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> q_stat.full)
        else $error("busy with room in the queue");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sample frame CRC-16 packer
// Sends four-sample beats through the start/busy command port and checks
// every strobed frame byte against a frame computed here: samples low byte
// first, then a CRC-16/MODBUS trailer, with frame_end on the last byte.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CHANNELS   = 4;
    // Only four sample ports exist; clamp the channel count to 1..4.
    localparam int FRAME_CH   = (CHANNELS < 1) ? 1 :
                                (CHANNELS > sfcp_pkg::SAMPLE_FIELDS) ?
                                sfcp_pkg::SAMPLE_FIELDS : CHANNELS;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_GAP     = 30;
    localparam int RAND_FRAMES = 34;

    // ------------------------------------------------------------------
    // Frame scoreboard: builds the expected byte stream for each accepted
    // beat and checks strobed bytes against it in order.
    // ------------------------------------------------------------------
    class frame_scoreboard;
        sfcp_pkg::byte_t expected_bytes[$];
        logic            expected_last[$];
        int              mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Build the frame for one accepted beat and queue its bytes.
        function void note_samples(
            input logic [sfcp_pkg::SAMPLE_W-1:0] smp [sfcp_pkg::SAMPLE_FIELDS]);
            sfcp_pkg::byte_t frame_bytes[$];
            sfcp_pkg::crc_t  crc;
            int              total;
            frame_bytes = {};
            for (int ch = 0; ch < FRAME_CH; ch++)
            begin
                frame_bytes.push_back(smp[ch][7:0]);
                frame_bytes.push_back(smp[ch][15:8]);
            end
            // Reflected CRC-16/MODBUS, LSB first, over the sample bytes only.
            crc = 16'hFFFF;
            foreach (frame_bytes[k])
            begin
                crc = crc ^ {8'h00, frame_bytes[k]};
                for (int b = 0; b < 8; b++)
                begin
                    if (crc[0])
                    begin
                        crc = (crc >> 1) ^ 16'hA001;
                    end
                    else
                    begin
                        crc = crc >> 1;
                    end
                end
            end
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
            total = frame_bytes.size();
            for (int i = 0; i < total; i++)
            begin
                expected_bytes.push_back(frame_bytes[i]);
                expected_last.push_back(i == total - 1);
            end
        endfunction

        // Compare one strobed byte with the oldest expected byte.
        function void check_byte(input sfcp_pkg::byte_t data, input logic last);
            sfcp_pkg::byte_t exp_data;
            logic            exp_last;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("tb_top: unexpected frame byte %02h frame_end=%0b",
                             data, last);
                end
                return;
            end
            exp_data = expected_bytes.pop_front();
            exp_last = expected_last.pop_front();
            if (data !== exp_data || last !== exp_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("tb_top: frame byte mismatch: expected %02h/%0b, got %02h/%0b",
                             exp_data, exp_last, data, last);
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic        strobe;
    logic [7:0]  tx_byte;
    logic        frame_end;

    frame_scoreboard sb;
    int          stall_cycles;
    int          sender_idle_pct;

    sample_frame_crc16_packer_top #(
        .CHANNELS (CHANNELS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample_0  (sample_0),
        .sample_1  (sample_1),
        .sample_2  (sample_2),
        .sample_3  (sample_3),
        .strobe    (strobe),
        .tx_byte   (tx_byte),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Check every strobed byte at the edge that accepts it; results cannot
    // be held off, so the strobe alone marks the beat.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            sb.check_byte(tx_byte, frame_end);
        end
    end

    // Watchdog: count cycles where neither side moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Draw a random number of idle cycles, capped so the watchdog stays quiet.
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
        begin
            n++;
        end
        return n;
    endfunction

    // Favor the field extremes, otherwise a full random pattern.
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(7))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'h0000;
            3:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Hold start low over the idle gap, then present the beat and hold it
    // until an edge sees busy low. Start stays high on return so the next
    // beat can follow back to back.
    task automatic send_frame(input logic [15:0] s0, input logic [15:0] s1,
                              input logic [15:0] s2, input logic [15:0] s3,
                              input int gap);
        logic [sfcp_pkg::SAMPLE_W-1:0] smp [sfcp_pkg::SAMPLE_FIELDS];
        smp[0] = s0;
        smp[1] = s1;
        smp[2] = s2;
        smp[3] = s3;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        sample_0 <= s0;
        sample_1 <= s1;
        sample_2 <= s2;
        sample_3 <= s3;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        sb.note_samples(smp);
    endtask

    task automatic send_random(input int count, input int pct);
        for (int i = 0; i < count; i++)
        begin
            send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       idle_gap(pct));
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        sample_0     = '0;
        sample_1     = '0;
        sample_2     = '0;
        sample_3     = '0;
        stall_cycles = 0;

        // Hold reset, then release it away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all-zero and all-one patterns, sign extremes, byte
        // order probes, and a distinct value per channel.
        send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
        send_frame(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 3);
        send_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
        send_frame(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 1);
        send_frame(16'h0001, 16'h0080, 16'h0100, 16'h8000, 0);
        send_frame(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 5);
        send_frame(16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
        send_frame(16'h0000, 16'h0000, 16'h0000, 16'h8000, 2);
        send_frame(16'hFFFE, 16'h0002, 16'hC000, 16'h4000, 0);

        // Random: sender idles now and then, then often, then never.
        sender_idle_pct = 37;
        send_random(RAND_FRAMES, sender_idle_pct);
        sender_idle_pct = 81;
        send_random(RAND_FRAMES, sender_idle_pct);
        sender_idle_pct = 0;
        send_random(RAND_FRAMES, sender_idle_pct);

        @(negedge clk);
        start <= 1'b0;

        // Drain: wait for the last frame, then watch for stray bytes.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sample_frame_crc16_packer_top.f
rtl/sfcp_pkg.sv
rtl/sfcp_front.sv
rtl/sfcp_queue.sv
rtl/sfcp_back.sv
rtl/sample_frame_crc16_packer_top.sv
sim/tb_top.sv
